@@ src/tmse_pkg.sv @@
// Shared types and codes for the Turing machine step engine.
package tmse_pkg;

    // Fixed field widths
    localparam int unsigned STATE_W  = 4;
    localparam int unsigned SYMBOL_W = 4;
    localparam int unsigned MOVE_W   = 2;
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned POS_W    = 12;
    localparam int unsigned COUNT_W  = 32;
    localparam int unsigned CFG_IDX_W = 1;

    // Rule table is addressed by {state, symbol}
    localparam int unsigned RULE_AW    = STATE_W + SYMBOL_W;
    localparam int unsigned RULE_DEPTH = 1 << RULE_AW;

    // Width that holds a state or symbol count up to 256
    localparam int unsigned LIMIT_W = 9;

    // Input item kinds
    localparam logic [KIND_W-1:0] KIND_LOAD    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RESTART = 2'd2;
    localparam logic [KIND_W-1:0] KIND_STEP    = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_DONE    = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_STEPPED = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_HALTED  = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_REJECT  = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_RANGE   = 3'd4;

    // Head move codes
    localparam logic [MOVE_W-1:0] MOVE_STAY  = 2'd0;
    localparam logic [MOVE_W-1:0] MOVE_LEFT  = 2'd1;
    localparam logic [MOVE_W-1:0] MOVE_RIGHT = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALT    = 1'b1;

    // Reset values of the configuration registers
    localparam logic [STATE_W-1:0] INITIAL_RESET = 4'd0;
    localparam logic [STATE_W-1:0] HALT_RESET    = 4'd15;

    // One rule table word
    typedef struct packed {
        logic                valid;
        logic [STATE_W-1:0]  goto_state;
        logic [SYMBOL_W-1:0] write_symbol;
        logic [MOVE_W-1:0]   move;
    } t_rule;

    localparam int unsigned RULE_W = $bits(t_rule);

    // Decision of one machine step, from the step unit to the sequencer
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [STATE_W-1:0]  goto_state;
        logic                write_en;
        logic [SYMBOL_W-1:0] write_symbol;
        logic                head_dec;
        logic                head_inc;
        logic                count_en;
    } t_step_ctl;

endpackage

@@ src/tmse_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module tmse_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data held until the next enabled read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/tmse_step.sv @@
// Step decision: rule match, halt check, head bounds and status of one step.
module tmse_step #(
    parameter int unsigned TAPE_DEPTH   = 4096,
    parameter int unsigned STATE_COUNT  = 16,
    parameter int unsigned SYMBOL_COUNT = 16
) (
    input  logic [$clog2(TAPE_DEPTH)-1:0]  i_head,
    input  logic [tmse_pkg::STATE_W-1:0]   i_state,
    input  logic [tmse_pkg::STATE_W-1:0]   i_halt_state,
    input  logic [tmse_pkg::SYMBOL_W-1:0]  i_read_symbol,
    input  tmse_pkg::t_rule                i_rule,
    output tmse_pkg::t_step_ctl            o_ctl
);

    localparam int unsigned HEAD_W = $clog2(TAPE_DEPTH);
    localparam int unsigned LIM_W  = tmse_pkg::LIMIT_W;
    localparam logic [HEAD_W-1:0] HEAD_LAST = HEAD_W'(TAPE_DEPTH - 1);

    logic key_ok;
    logic halted;

    // A rule matches only for keys inside the table and with its valid bit set
    assign key_ok = (LIM_W'(i_state) < LIM_W'(STATE_COUNT))
                 && (LIM_W'(i_read_symbol) < LIM_W'(SYMBOL_COUNT))
                 && i_rule.valid;
    assign halted = (i_state == i_halt_state);

    // Decide status, state change, tape write and head move
    always_comb begin
        o_ctl              = '0;
        o_ctl.status       = tmse_pkg::STAT_REJECT;
        o_ctl.goto_state   = i_state;
        o_ctl.write_symbol = i_rule.write_symbol;
        if (halted) begin
            o_ctl.status = tmse_pkg::STAT_HALTED;
        end else if (key_ok) begin
            o_ctl.write_en   = 1'b1;
            o_ctl.count_en   = 1'b1;
            o_ctl.goto_state = i_rule.goto_state;
            o_ctl.status     = (i_rule.goto_state == i_halt_state) ? tmse_pkg::STAT_HALTED
                                                                   : tmse_pkg::STAT_STEPPED;
            // Out-of-range move keeps the head and overrides halted
            case (i_rule.move)
                tmse_pkg::MOVE_LEFT: begin
                    if (i_head == '0) begin
                        o_ctl.status = tmse_pkg::STAT_RANGE;
                    end else begin
                        o_ctl.head_dec = 1'b1;
                    end
                end
                tmse_pkg::MOVE_RIGHT: begin
                    if (i_head == HEAD_LAST) begin
                        o_ctl.status = tmse_pkg::STAT_RANGE;
                    end else begin
                        o_ctl.head_inc = 1'b1;
                    end
                end
                default: begin
                    o_ctl.head_dec = 1'b0;
                end
            endcase
        end
    end

endmodule

@@ src/turing_machine_step_engine.sv @@
// Top level of the single-tape Turing machine step engine.
//
//   channel  direction  handshake                  payload
//   in       to block   i_in_valid / o_in_stall    kind, rule, symbol, position
//   out      from block o_out_valid / i_out_stall  status, state, head, symbol, count
//   cfg      to block   i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// Rule loads, tape writes and restarts finish in idle. A machine step reads the tape at
// the head, reads the rule table at {state, symbol}, then does the tape write-back and
// register update once the result register can take it; both tables are synchronous
// RAMs. After reset a clearing pass over max(TAPE_DEPTH, 256) addresses zeroes both
// RAMs; the input is stalled during it, configuration writes are taken throughout. A
// new item is taken in idle once the result register is empty or being transferred.
module turing_machine_step_engine #(
    parameter int unsigned TAPE_DEPTH   = 4096,
    parameter int unsigned STATE_COUNT  = 16,
    parameter int unsigned SYMBOL_COUNT = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input items
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [tmse_pkg::KIND_W-1:0]         i_kind,
    input  logic [tmse_pkg::STATE_W-1:0]        i_rule_state,
    input  logic [tmse_pkg::SYMBOL_W-1:0]       i_symbol,
    input  logic [tmse_pkg::STATE_W-1:0]        i_next_state,
    input  logic [tmse_pkg::SYMBOL_W-1:0]       i_write_symbol,
    input  logic [tmse_pkg::MOVE_W-1:0]         i_move,
    input  logic [tmse_pkg::POS_W-1:0]          i_position,
    // result items
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [tmse_pkg::STATUS_W-1:0]       o_status,
    output logic [tmse_pkg::STATE_W-1:0]        o_machine_state,
    output logic [tmse_pkg::POS_W-1:0]          o_head_position,
    output logic [tmse_pkg::SYMBOL_W-1:0]       o_read_symbol,
    output logic [tmse_pkg::COUNT_W-1:0]        o_step_count,
    // configuration writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [tmse_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tmse_pkg::STATE_W-1:0]        i_cfg_data
);

    localparam int unsigned HEAD_W    = $clog2(TAPE_DEPTH);
    localparam int unsigned CLR_DEPTH = (TAPE_DEPTH > tmse_pkg::RULE_DEPTH)
                                      ? TAPE_DEPTH : tmse_pkg::RULE_DEPTH;
    localparam int unsigned CLR_W     = $clog2(CLR_DEPTH);
    localparam int unsigned POS_CMP_W = ((CLR_W > tmse_pkg::POS_W) ? CLR_W : tmse_pkg::POS_W) + 1;
    localparam logic [CLR_W-1:0]  CLR_LAST   = CLR_W'(CLR_DEPTH - 1);
    localparam logic [HEAD_W-1:0] HEAD_RESET = HEAD_W'(TAPE_DEPTH / 2);
    localparam int unsigned LIM_W = tmse_pkg::LIMIT_W;

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_LOOKUP = 5'b00100,
        S_APPLY  = 5'b01000,
        S_SPARE  = 5'b10000
    } t_seq_state;

    // Control registers
    t_seq_state                        r_seq, n_seq;
    logic [CLR_W-1:0]                  r_clr_cnt, n_clr_cnt;
    logic [tmse_pkg::STATE_W-1:0]      r_state, n_state;
    logic [HEAD_W-1:0]                 r_head, n_head;
    logic [tmse_pkg::COUNT_W-1:0]      r_count, n_count;
    logic [tmse_pkg::STATE_W-1:0]      r_initial, r_halt;
    logic                              r_out_valid, n_out_valid;

    // Result payload registers
    logic [tmse_pkg::STATUS_W-1:0]     r_out_status, n_out_status;
    logic [tmse_pkg::SYMBOL_W-1:0]     r_out_symbol, n_out_symbol;
    logic [tmse_pkg::STATE_W-1:0]      r_out_state;
    logic [HEAD_W-1:0]                 r_out_head;
    logic [tmse_pkg::COUNT_W-1:0]      r_out_count;

    // RAM ports
    logic                              tape_we, tape_re;
    logic [HEAD_W-1:0]                 tape_waddr;
    logic [tmse_pkg::SYMBOL_W-1:0]     tape_wdata, tape_rdata;
    logic                              rule_we, rule_re;
    logic [tmse_pkg::RULE_AW-1:0]      rule_waddr, rule_raddr;
    logic [tmse_pkg::RULE_W-1:0]       rule_wdata, rule_rdata;

    logic                              out_free, in_accept, out_load;
    logic                              load_key_ok, pos_ok, clr_tape_ok;
    tmse_pkg::t_rule                   load_rule;
    tmse_pkg::t_step_ctl               step_ctl;

    tmse_ram #(
        .WIDTH (tmse_pkg::SYMBOL_W),
        .DEPTH (TAPE_DEPTH)
    ) u_tape (
        .i_clk   (i_clk),
        .i_we    (tape_we),
        .i_waddr (tape_waddr),
        .i_wdata (tape_wdata),
        .i_re    (tape_re),
        .i_raddr (r_head),
        .o_rdata (tape_rdata)
    );

    tmse_ram #(
        .WIDTH (tmse_pkg::RULE_W),
        .DEPTH (tmse_pkg::RULE_DEPTH)
    ) u_rules (
        .i_clk   (i_clk),
        .i_we    (rule_we),
        .i_waddr (rule_waddr),
        .i_wdata (rule_wdata),
        .i_re    (rule_re),
        .i_raddr (rule_raddr),
        .o_rdata (rule_rdata)
    );

    tmse_step #(
        .TAPE_DEPTH   (TAPE_DEPTH),
        .STATE_COUNT  (STATE_COUNT),
        .SYMBOL_COUNT (SYMBOL_COUNT)
    ) u_step (
        .i_head        (r_head),
        .i_state       (r_state),
        .i_halt_state  (r_halt),
        .i_read_symbol (tape_rdata),
        .i_rule        (tmse_pkg::t_rule'(rule_rdata)),
        .o_ctl         (step_ctl)
    );

    // Handshakes
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = !((r_seq == S_IDLE) && out_free);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // Range checks on item fields
    assign load_key_ok = (LIM_W'(i_rule_state) < LIM_W'(STATE_COUNT))
                      && (LIM_W'(i_symbol) < LIM_W'(SYMBOL_COUNT));
    assign pos_ok      = POS_CMP_W'(i_position) < POS_CMP_W'(TAPE_DEPTH);
    assign clr_tape_ok = POS_CMP_W'(r_clr_cnt) < POS_CMP_W'(TAPE_DEPTH);

    always_comb begin
        load_rule              = '0;
        load_rule.valid        = 1'b1;
        load_rule.goto_state   = i_next_state;
        load_rule.write_symbol = i_write_symbol;
        load_rule.move         = i_move;
    end

    // Rule table read: key of the current state and the symbol just read
    assign rule_re    = (r_seq == S_LOOKUP);
    assign rule_raddr = {r_state, tape_rdata};

    // Sequencer, RAM writes and register updates
    always_comb begin
        n_seq        = r_seq;
        n_clr_cnt    = r_clr_cnt;
        n_state      = r_state;
        n_head       = r_head;
        n_count      = r_count;
        n_out_status = tmse_pkg::STAT_DONE;
        n_out_symbol = '0;
        out_load     = 1'b0;
        tape_we      = 1'b0;
        tape_re      = 1'b0;
        tape_waddr   = r_head;
        tape_wdata   = '0;
        rule_we      = 1'b0;
        rule_waddr   = {i_rule_state, i_symbol};
        rule_wdata   = load_rule;

        unique case (r_seq)
            S_CLEAR: begin
                // Sweep both RAMs with zeros
                tape_we    = clr_tape_ok;
                tape_waddr = HEAD_W'(r_clr_cnt);
                rule_we    = 1'b1;
                rule_waddr = tmse_pkg::RULE_AW'(r_clr_cnt);
                rule_wdata = '0;
                n_clr_cnt  = r_clr_cnt + 1'b1;
                if (r_clr_cnt == CLR_LAST) begin
                    n_seq = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    unique case (i_kind)
                        tmse_pkg::KIND_LOAD: begin
                            rule_we  = load_key_ok;
                            out_load = 1'b1;
                        end
                        tmse_pkg::KIND_WRITE: begin
                            tape_we    = pos_ok;
                            tape_waddr = HEAD_W'(i_position);
                            tape_wdata = i_symbol;
                            out_load   = 1'b1;
                        end
                        tmse_pkg::KIND_RESTART: begin
                            n_head   = HEAD_RESET;
                            n_state  = r_initial;
                            n_count  = '0;
                            out_load = 1'b1;
                        end
                        tmse_pkg::KIND_STEP: begin
                            tape_re = 1'b1;
                            n_seq   = S_LOOKUP;
                        end
                    endcase
                end
            end
            S_LOOKUP: begin
                n_seq = S_APPLY;
            end
            S_APPLY: begin
                // Commit the step once the result register can take it
                if (out_free) begin
                    tape_we      = step_ctl.write_en;
                    tape_wdata   = step_ctl.write_symbol;
                    n_state      = step_ctl.goto_state;
                    if (step_ctl.head_inc) begin
                        n_head = r_head + 1'b1;
                    end else if (step_ctl.head_dec) begin
                        n_head = r_head - 1'b1;
                    end
                    if (step_ctl.count_en && !(&r_count)) begin
                        n_count = r_count + 1'b1;
                    end
                    n_out_status = step_ctl.status;
                    n_out_symbol = tape_rdata;
                    out_load     = 1'b1;
                    n_seq        = S_IDLE;
                end
            end
            default: begin
                n_seq = S_IDLE;
            end
        endcase
    end

    // Result register valid: set on a finished item, drop on transfer
    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq       <= S_CLEAR;
            r_clr_cnt   <= '0;
            r_state     <= '0;
            r_head      <= HEAD_RESET;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_seq       <= n_seq;
            r_clr_cnt   <= n_clr_cnt;
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_initial <= tmse_pkg::INITIAL_RESET;
            r_halt    <= tmse_pkg::HALT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                tmse_pkg::CFG_INITIAL: r_initial <= i_cfg_data;
                tmse_pkg::CFG_HALT:    r_halt    <= i_cfg_data;
                default:               r_halt    <= r_halt;
            endcase
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_status <= n_out_status;
            r_out_state  <= n_state;
            r_out_head   <= n_head;
            r_out_symbol <= n_out_symbol;
            r_out_count  <= n_count;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_machine_state = r_out_state;
    assign o_head_position = tmse_pkg::POS_W'(r_out_head);
    assign o_read_symbol   = r_out_symbol;
    assign o_step_count    = r_out_count;

endmodule
